// ----- hw/rtl/ipv4chk_pkg.sv -----
// Package for the IPv4 header receive check: constants, verdict codes and
// the structs passed between the top level and the verdict logic.
// No dependencies.
package ipv4chk_pkg;

	// Header layout and check constants
	localparam int unsigned MIN_HEADER_BYTES = 20;
	localparam logic [3:0]  IPV4_VERSION     = 4'd4;
	localparam logic [15:0] MF_FLAG_MASK     = 16'h2000;
	localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1fff;
	localparam logic [31:0] LIMITED_BCAST    = 32'hffffffff;
	localparam logic [15:0] COUNT_MAX        = 16'hffff;
	localparam logic [15:0] CSUM_GOOD        = 16'hffff;

	// Header byte offsets
	localparam logic [5:0] OFS_VER_IHL    = 6'd0;
	localparam logic [5:0] OFS_TOTAL_HI   = 6'd2;
	localparam logic [5:0] OFS_TOTAL_LO   = 6'd3;
	localparam logic [5:0] OFS_FLAGS_HI   = 6'd6;
	localparam logic [5:0] OFS_FLAGS_LO   = 6'd7;
	localparam logic [5:0] OFS_PROTOCOL   = 6'd9;
	localparam logic [5:0] OFS_SRC_FIRST  = 6'd12;
	localparam logic [5:0] OFS_SRC_LAST   = 6'd15;
	localparam logic [5:0] OFS_DST_FIRST  = 6'd16;
	localparam logic [5:0] OFS_DST_LAST   = 6'd19;

	// Configuration register indexes (byte address = 4 * index)
	localparam int unsigned PADDR_W = 4;
	typedef enum logic [1:0] {
		REG_LOCAL_UNICAST   = 2'd0,
		REG_LOCAL_BROADCAST = 2'd1,
		REG_IFACE_PRESENT   = 2'd2,
		REG_UNUSED          = 2'd3
	} reg_idx_t;

	localparam logic [31:0] RST_LOCAL_UNICAST   = 32'h0000_0000;
	localparam logic [31:0] RST_LOCAL_BROADCAST = 32'hffff_ffff;

	// Verdict codes, first failing check wins
	typedef enum logic [3:0] {
		VERDICT_ACCEPT    = 4'd0,
		VERDICT_SHORT     = 4'd1,
		VERDICT_VERSION   = 4'd2,
		VERDICT_HDRLEN    = 4'd3,
		VERDICT_TOTAL     = 4'd4,
		VERDICT_CHECKSUM  = 4'd5,
		VERDICT_FRAGMENT  = 4'd6,
		VERDICT_NO_IFACE  = 4'd7,
		VERDICT_NOT_OURS  = 4'd8
	} verdict_t;

	// Captured header state of a finished packet
	typedef struct packed {
		logic [15:0] pkt_len;
		logic [7:0]  version_ihl;
		logic [15:0] total_field;
		logic [15:0] flags_offset;
		logic [31:0] dest_field;
		logic [16:0] sum_acc;
	} hdr_t;

	// Interface configuration
	typedef struct packed {
		logic [31:0] local_unicast;
		logic [31:0] local_broadcast;
		logic        iface_present;
	} cfg_t;

endpackage

// ----- hw/rtl/ipv4chk_in_if.sv -----
// Input channel: one packet byte per word with a last-byte flag.
// Valid/ready handshake. No dependencies.
interface ipv4chk_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/ipv4chk_out_if.sv -----
// Output channel: one verdict word per packet with the captured fields.
// Valid/ready handshake. No dependencies.
interface ipv4chk_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  verdict;
	logic [7:0]  protocol_number;
	logic [15:0] total_length;
	logic [5:0]  header_length;
	logic [31:0] source_address;

	modport source (output valid, output verdict, output protocol_number,
		output total_length, output header_length, output source_address,
		input ready);
	modport sink   (input valid, input verdict, input protocol_number,
		input total_length, input header_length, input source_address,
		output ready);
endinterface

// ----- hw/rtl/ipv4chk_verdict.sv -----
// Verdict logic: ordered header checks on a finished packet.
// Depends on ipv4chk_pkg.
module ipv4chk_verdict (
	input  ipv4chk_pkg::hdr_t     hdr,
	input  ipv4chk_pkg::cfg_t     cfg,
	output ipv4chk_pkg::verdict_t verdict
);
	import ipv4chk_pkg::*;

	logic [15:0] hlen;
	logic [15:0] folded;
	logic        dest_ok;
	logic        frag;

	// Header length in bytes and final fold of the checksum
	assign hlen    = {10'd0, hdr.version_ihl[3:0], 2'b00};
	assign folded  = hdr.sum_acc[15:0] + {15'd0, hdr.sum_acc[16]};
	assign frag    = ((hdr.flags_offset & MF_FLAG_MASK) != '0) ||
		((hdr.flags_offset & FRAG_OFFSET_MASK) != '0);
	assign dest_ok = (hdr.dest_field == cfg.local_unicast) ||
		(hdr.dest_field == LIMITED_BCAST) ||
		(hdr.dest_field == cfg.local_broadcast);

	// Checks in priority order
	always_comb begin
		if (hdr.pkt_len < 16'(MIN_HEADER_BYTES)) begin
			verdict = VERDICT_SHORT;
		end else if (hdr.version_ihl[7:4] != IPV4_VERSION) begin
			verdict = VERDICT_VERSION;
		end else if (hlen < 16'(MIN_HEADER_BYTES) || hdr.pkt_len < hlen) begin
			verdict = VERDICT_HDRLEN;
		end else if (hdr.pkt_len < hdr.total_field) begin
			verdict = VERDICT_TOTAL;
		end else if (folded != CSUM_GOOD) begin
			verdict = VERDICT_CHECKSUM;
		end else if (frag) begin
			verdict = VERDICT_FRAGMENT;
		end else if (!cfg.iface_present) begin
			verdict = VERDICT_NO_IFACE;
		end else if (!dest_ok) begin
			verdict = VERDICT_NOT_OURS;
		end else begin
			verdict = VERDICT_ACCEPT;
		end
	end

endmodule

// ----- hw/rtl/ipv4_header_receive_check_top.sv -----
// IPv4 header receive check, top level: byte input register, header capture,
// ones-complement sum, verdict register and the APB configuration registers.
// Depends on ipv4chk_pkg, ipv4chk_in_if, ipv4chk_out_if, ipv4chk_verdict.
// The last byte passes through the input register, then the verdict and the
// captured fields load into the result register once it is free.
// Throughput: one byte per cycle; input stalls only while a verdict waits in
// the result register and the next last byte reaches the input register.
// Reset: arst_n clears all packet state and returns the configuration
// registers to unicast 0, broadcast all ones, no interface.
module ipv4_header_receive_check_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	ipv4chk_in_if.sink                             in_ch,
	ipv4chk_out_if.source                          out_ch,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [ipv4chk_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);
	import ipv4chk_pkg::*;

	// Configuration registers
	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Per-packet state
	logic [15:0] count_q;
	logic [16:0] sum_q;
	logic [7:0]  hold_q;
	logic [7:0]  vi_q;
	logic [15:0] total_q;
	logic [15:0] flags_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;

	// Next packet state
	logic [15:0] count_n;
	logic [16:0] sum_n;
	logic [7:0]  hold_n;
	logic [7:0]  vi_n;
	logic [15:0] total_n;
	logic [15:0] flags_n;
	logic [7:0]  proto_n;
	logic [31:0] src_n;
	logic [31:0] dst_n;

	logic        in_hdr;
	logic [5:0]  idx;
	logic [5:0]  hlen_n;
	logic [17:0] word_sum;
	logic [16:0] word_fold;

	// Result register
	logic        out_valid_q;
	verdict_t    res_verdict_q;
	logic [7:0]  res_proto_q;
	logic [15:0] res_total_q;
	logic [5:0]  res_hlen_q;
	logic [31:0] res_src_q;

	logic     out_free;
	logic     advance;
	hdr_t     hdr;
	verdict_t verdict;

	// APB write/read
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_unicast   <= RST_LOCAL_UNICAST;
			cfg_q.local_broadcast <= RST_LOCAL_BROADCAST;
			cfg_q.iface_present   <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LOCAL_UNICAST:   cfg_q.local_unicast   <= pwdata;
				REG_LOCAL_BROADCAST: cfg_q.local_broadcast <= pwdata;
				REG_IFACE_PRESENT:   cfg_q.iface_present   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LOCAL_UNICAST:   prdata = cfg_q.local_unicast;
			REG_LOCAL_BROADCAST: prdata = cfg_q.local_broadcast;
			REG_IFACE_PRESENT:   prdata = {31'd0, cfg_q.iface_present};
			default:             prdata = '0;
		endcase
	end

	// Handshake: only a last byte needs the result register
	assign out_free    = !out_valid_q || out_ch.ready;
	assign advance     = valid_s1 && (!last_s1 || out_free);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// Header capture and running sum for the byte in the input register
	assign in_hdr = (count_q[15:6] == '0);
	assign idx    = count_q[5:0];

	always_comb begin
		vi_n    = vi_q;
		total_n = total_q;
		flags_n = flags_q;
		proto_n = proto_q;
		src_n   = src_q;
		dst_n   = dst_q;
		if (in_hdr) begin
			case (idx)
				OFS_VER_IHL:  vi_n          = byte_s1;
				OFS_TOTAL_HI: total_n[15:8] = byte_s1;
				OFS_TOTAL_LO: total_n[7:0]  = byte_s1;
				OFS_FLAGS_HI: flags_n[15:8] = byte_s1;
				OFS_FLAGS_LO: flags_n[7:0]  = byte_s1;
				OFS_PROTOCOL: proto_n       = byte_s1;
				default: ;
			endcase
			if (idx >= OFS_SRC_FIRST && idx <= OFS_SRC_LAST) begin
				src_n = {src_q[23:0], byte_s1};
			end
			if (idx >= OFS_DST_FIRST && idx <= OFS_DST_LAST) begin
				dst_n = {dst_q[23:0], byte_s1};
			end
		end
	end

	assign hlen_n    = {vi_n[3:0], 2'b00};
	assign word_sum  = {1'b0, sum_q} + {2'b00, hold_q, byte_s1};
	assign word_fold = {1'b0, word_sum[15:0]} + {15'd0, word_sum[17:16]};

	always_comb begin
		hold_n = hold_q;
		sum_n  = sum_q;
		if (in_hdr && idx < hlen_n) begin
			if (!idx[0]) begin
				hold_n = byte_s1;
			end else begin
				sum_n = word_fold;
			end
		end
	end

	assign count_n = (count_q == COUNT_MAX) ? count_q : count_q + 16'd1;

	// Packet state: cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			hold_q  <= '0;
			vi_q    <= '0;
			total_q <= '0;
			flags_q <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				count_q <= '0;
				sum_q   <= '0;
				hold_q  <= '0;
				vi_q    <= '0;
				total_q <= '0;
				flags_q <= '0;
				proto_q <= '0;
				src_q   <= '0;
				dst_q   <= '0;
			end else begin
				count_q <= count_n;
				sum_q   <= sum_n;
				hold_q  <= hold_n;
				vi_q    <= vi_n;
				total_q <= total_n;
				flags_q <= flags_n;
				proto_q <= proto_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
			end
		end
	end

	// Verdict on the state including the last byte
	assign hdr.pkt_len      = count_n;
	assign hdr.version_ihl  = vi_n;
	assign hdr.total_field  = total_n;
	assign hdr.flags_offset = flags_n;
	assign hdr.dest_field   = dst_n;
	assign hdr.sum_acc      = sum_n;

	ipv4chk_verdict u_verdict (
		.hdr     (hdr),
		.cfg     (cfg_q),
		.verdict (verdict)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_verdict_q <= verdict;
			res_proto_q   <= proto_n;
			res_total_q   <= total_n;
			res_hlen_q    <= hlen_n;
			res_src_q     <= src_n;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.verdict         = res_verdict_q;
	assign out_ch.protocol_number = res_proto_q;
	assign out_ch.total_length    = res_total_q;
	assign out_ch.header_length   = res_hlen_q;
	assign out_ch.source_address  = res_src_q;

endmodule
